// ===== sv/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared constants, codes and structs of the coupling-table bilinear lookup.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int SLOTS_PER_SIDE = 4;
  localparam int GRID_POINTS    = 32;
  localparam int LIST_MAX       = 4;

  // slots that the packed orbital lists can actually hold
  localparam int MATCH_SLOTS = (LIST_MAX < SLOTS_PER_SIDE) ? LIST_MAX : SLOTS_PER_SIDE;

  localparam int SLOT_W  = $clog2(SLOTS_PER_SIDE);
  localparam int GRID_W  = $clog2(GRID_POINTS);
  // four banks split by grid parity, each holds half the grid on both axes
  localparam int NUM_BANKS = 4;
  localparam int BANK_AW   = 2 * SLOT_W + 2 * (GRID_W - 1);

  localparam int VAL_W = 24;   // Q7.16 sample and result
  localparam int OFF_W = 24;   // d + r, unsigned
  localparam int PTS_W = 6;    // grid point count register

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_NOPAIR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CUTOFF   = 3'd0,
    REG_INV_X    = 3'd1,
    REG_INV_Y    = 3'd2,
    REG_POINTS_X = 3'd3,
    REG_POINTS_Y = 3'd4,
    REG_ROW_LIST = 3'd5,
    REG_COL_LIST = 3'd6,
    REG_COUNTS   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [21:0]      cutoff;
    logic [23:0]      inv_x;
    logic [23:0]      inv_y;
    logic [PTS_W-1:0] points_x;
    logic [PTS_W-1:0] points_y;
    logic [15:0]      row_list;
    logic [15:0]      col_list;
    logic [6:0]       counts;
  } cfg_t;

  typedef struct packed {
    logic                    mode;
    logic [1:0]              table_row_slot;
    logic [1:0]              table_col_slot;
    logic [4:0]              grid_x;
    logic [4:0]              grid_y;
    logic signed [VAL_W-1:0] sample_value;
    logic [3:0]              row_orb;
    logic [3:0]              col_orb;
    logic signed [23:0]      disp_x;
    logic signed [23:0]      disp_y;
    logic                    disp_z_negative;
  } in_item_t;

  // after swap, cutoff test and pair match
  typedef struct packed {
    logic                    vld;
    logic                    query;
    status_t                 status;
    logic [SLOT_W-1:0]       row_slot;
    logic [SLOT_W-1:0]       col_slot;
    logic [OFF_W-1:0]        off_x;
    logic [OFF_W-1:0]        off_y;
    logic [GRID_W-1:0]       gx;
    logic [GRID_W-1:0]       gy;
    logic signed [VAL_W-1:0] sample;
  } front_t;

  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] value;
    status_t          status;
  } result_t;

endpackage

// ===== sv/ctb_ram.sv =====
// ----------------------------------------------------------------------------
// ctb_ram
// Single-port synchronous RAM, registered read, read data holds when idle.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/ctb_front.sv =====
// ----------------------------------------------------------------------------
// ctb_front
// Entry stage: orbital swap and negation, cutoff square test, pair match.
// ----------------------------------------------------------------------------
module ctb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              accept,
  input  ctb_pkg::cfg_t     cfg,
  input  ctb_pkg::in_item_t item,
  output ctb_pkg::front_t   stage
);

  logic [3:0]                 orow;
  logic [3:0]                 ocol;
  logic signed [24:0]         dx;
  logic signed [24:0]         dy;
  logic signed [24:0]         r;
  logic signed [24:0]         sum_x;
  logic signed [24:0]         sum_y;
  logic                       outside;
  logic [3:0]                 nr;
  logic [3:0]                 nc;
  logic                       rhit;
  logic                       chit;
  logic [ctb_pkg::SLOT_W-1:0] ri;
  logic [ctb_pkg::SLOT_W-1:0] ci;
  ctb_pkg::front_t            stage_next;

  function automatic logic [3:0] eff_count(input logic [3:0] n);
    logic [3:0] m;
    m = (n > 4'(ctb_pkg::MATCH_SLOTS)) ? 4'(ctb_pkg::MATCH_SLOTS) : n;
    return m;
  endfunction

  always_comb begin
    // downward hop: swap orbitals, flip displacement
    if (item.disp_z_negative) begin
      orow = item.col_orb;
      ocol = item.row_orb;
      dx   = -25'(item.disp_x);
      dy   = -25'(item.disp_y);
    end else begin
      orow = item.row_orb;
      ocol = item.col_orb;
      dx   = 25'(item.disp_x);
      dy   = 25'(item.disp_y);
    end
    r       = $signed({3'b000, cfg.cutoff});
    outside = (dx > r) || (dx < -r) || (dy > r) || (dy < -r);
    sum_x   = dx + r;
    sum_y   = dy + r;

    nr   = eff_count(cfg.counts[3:0]);
    nc   = eff_count({1'b0, cfg.counts[6:4]});
    rhit = 1'b0;
    chit = 1'b0;
    ri   = '0;
    ci   = '0;
    // descending scan leaves the lowest matching slot
    for (int i = ctb_pkg::MATCH_SLOTS - 1; i >= 0; i--) begin
      if (4'(i) < nr && cfg.row_list[4*i +: 4] == orow) begin
        rhit = 1'b1;
        ri   = ctb_pkg::SLOT_W'(i);
      end
      if (4'(i) < nc && cfg.col_list[4*i +: 4] == ocol) begin
        chit = 1'b1;
        ci   = ctb_pkg::SLOT_W'(i);
      end
    end

    stage_next.vld   = accept;
    stage_next.query = item.mode;
    if (outside) begin
      stage_next.status = ctb_pkg::STAT_OUTSIDE;
    end else if (!(rhit && chit)) begin
      stage_next.status = ctb_pkg::STAT_NOPAIR;
    end else begin
      stage_next.status = ctb_pkg::STAT_OK;
    end
    stage_next.row_slot = item.mode ? ri : ctb_pkg::SLOT_W'(item.table_row_slot);
    stage_next.col_slot = item.mode ? ci : ctb_pkg::SLOT_W'(item.table_col_slot);
    stage_next.off_x    = sum_x[ctb_pkg::OFF_W-1:0];
    stage_next.off_y    = sum_y[ctb_pkg::OFF_W-1:0];
    stage_next.gx       = ctb_pkg::GRID_W'(item.grid_x);
    stage_next.gy       = ctb_pkg::GRID_W'(item.grid_y);
    stage_next.sample   = item.sample_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== sv/ctb_interp.sv =====
// ----------------------------------------------------------------------------
// ctb_interp
// Grid position, banked table access and bilinear blend with saturation.
// ----------------------------------------------------------------------------
module ctb_interp (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  ctb_pkg::cfg_t     cfg,
  input  ctb_pkg::front_t   a,
  output ctb_pkg::result_t  res
);

  localparam logic [16:0] ONE = 17'h10000;

  // stage B: scaled position
  logic                             b_vld;
  logic                             b_query;
  ctb_pkg::status_t                 b_status;
  logic [ctb_pkg::SLOT_W-1:0]       b_rs;
  logic [ctb_pkg::SLOT_W-1:0]       b_cs;
  logic [47:0]                      b_ux;
  logic [47:0]                      b_uy;
  logic [ctb_pkg::GRID_W-1:0]       b_gx;
  logic [ctb_pkg::GRID_W-1:0]       b_gy;
  logic signed [ctb_pkg::VAL_W-1:0] b_sample;
  logic [47:0]                      ux_next;
  logic [47:0]                      uy_next;

  // index, fraction, weights
  logic [ctb_pkg::PTS_W-1:0]  lim_x;
  logic [ctb_pkg::PTS_W-1:0]  lim_y;
  logic                       over_x;
  logic                       over_y;
  logic [ctb_pkg::GRID_W-1:0] ix;
  logic [ctb_pkg::GRID_W-1:0] iy;
  logic [16:0]                fx;
  logic [16:0]                fy;
  logic [16:0]                wx0;
  logic [16:0]                wy0;
  logic [33:0]                w_next [4];

  // stage C: weights beside the bank read data
  logic                       c_vld;
  ctb_pkg::status_t           c_status;
  logic                       c_x0;
  logic                       c_y0;
  logic [32:0]                c_w [4];
  logic [ctb_pkg::VAL_W-1:0]  rdata [ctb_pkg::NUM_BANKS];
  logic [1:0]                 sel [4];
  logic signed [57:0]         p_next [4];

  // stage D: weighted samples
  logic                       d_vld;
  ctb_pkg::status_t           d_status;
  logic signed [57:0]         d_p [4];
  logic signed [59:0]         sum;
  logic signed [27:0]         q;
  logic [ctb_pkg::VAL_W-1:0]  sat;

  function automatic logic [ctb_pkg::PTS_W-1:0] eff_points(
    input logic [ctb_pkg::PTS_W-1:0] g
  );
    logic [ctb_pkg::PTS_W-1:0] h;
    h = g;
    if (h < ctb_pkg::PTS_W'(2)) h = ctb_pkg::PTS_W'(2);
    if (h > ctb_pkg::PTS_W'(ctb_pkg::GRID_POINTS)) h = ctb_pkg::PTS_W'(ctb_pkg::GRID_POINTS);
    return h;
  endfunction

  assign ux_next = a.off_x * cfg.inv_x;
  assign uy_next = a.off_y * cfg.inv_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_query  <= a.query;
      b_status <= a.status;
      b_rs     <= a.row_slot;
      b_cs     <= a.col_slot;
      b_ux     <= ux_next;
      b_uy     <= uy_next;
      b_gx     <= a.gx;
      b_gy     <= a.gy;
      b_sample <= a.sample;
    end
  end

  // clamp so the upper neighbor stays on the grid
  always_comb begin
    lim_x  = eff_points(cfg.points_x) - ctb_pkg::PTS_W'(2);
    lim_y  = eff_points(cfg.points_y) - ctb_pkg::PTS_W'(2);
    over_x = b_ux[47:32] > 16'(lim_x);
    over_y = b_uy[47:32] > 16'(lim_y);
    ix     = over_x ? lim_x[ctb_pkg::GRID_W-1:0] : b_ux[32 +: ctb_pkg::GRID_W];
    iy     = over_y ? lim_y[ctb_pkg::GRID_W-1:0] : b_uy[32 +: ctb_pkg::GRID_W];
    fx     = over_x ? ONE : {1'b0, b_ux[31:16]};
    fy     = over_y ? ONE : {1'b0, b_uy[31:16]};
    wx0    = ONE - fx;
    wy0    = ONE - fy;
    w_next[0] = wx0 * wy0;
    w_next[1] = fx * wy0;
    w_next[2] = wx0 * fy;
    w_next[3] = fx * fy;
  end

  // bank {x parity, y parity}; loads and queries hit the banks at the same
  // stage, so table accesses keep request order and need no forwarding
  for (genvar bi = 0; bi < ctb_pkg::NUM_BANKS; bi++) begin : g_bank
    localparam logic [1:0] BID = 2'(bi);
    logic [ctb_pkg::GRID_W-1:0]  xs;
    logic [ctb_pkg::GRID_W-1:0]  ys;
    logic [ctb_pkg::BANK_AW-1:0] addr;
    logic                        we;

    assign xs = ix + ctb_pkg::GRID_W'(ix[0] ^ BID[1]);
    assign ys = iy + ctb_pkg::GRID_W'(iy[0] ^ BID[0]);
    assign addr = b_query ?
        {b_rs, b_cs, xs[ctb_pkg::GRID_W-1:1], ys[ctb_pkg::GRID_W-1:1]} :
        {b_rs, b_cs, b_gx[ctb_pkg::GRID_W-1:1], b_gy[ctb_pkg::GRID_W-1:1]};
    assign we = b_vld && !b_query && ({b_gx[0], b_gy[0]} == BID);

    ctb_ram #(
      .ADDR_W (ctb_pkg::BANK_AW),
      .DATA_W (ctb_pkg::VAL_W)
    ) u_bank (
      .clk   (clk),
      .en    (adv),
      .we    (we),
      .addr  (addr),
      .wdata (b_sample),
      .rdata (rdata[bi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld && b_query;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_status <= b_status;
      c_x0     <= ix[0];
      c_y0     <= iy[0];
      for (int k = 0; k < 4; k++) begin
        c_w[k] <= w_next[k][32:0];
      end
    end
  end

  // corners in weight order: (ix,iy) (ix+1,iy) (ix,iy+1) (ix+1,iy+1)
  always_comb begin
    sel[0] = {c_x0, c_y0};
    sel[1] = {~c_x0, c_y0};
    sel[2] = {c_x0, ~c_y0};
    sel[3] = {~c_x0, ~c_y0};
    for (int k = 0; k < 4; k++) begin
      p_next[k] = $signed(rdata[sel[k]]) * $signed({1'b0, c_w[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_status <= c_status;
      for (int k = 0; k < 4; k++) begin
        d_p[k] <= p_next[k];
      end
    end
  end

  // round half up, floor shift by 32, saturate to Q7.16
  always_comb begin
    sum = 60'(d_p[0]) + 60'(d_p[1]) + 60'(d_p[2]) + 60'(d_p[3])
        + 60'sd2147483648;
    q   = sum[59:32];
    if (q > 28'sd8388607) begin
      sat = 24'h7FFFFF;
    end else if (q < -28'sd8388608) begin
      sat = 24'h800000;
    end else begin
      sat = q[ctb_pkg::VAL_W-1:0];
    end
    res.vld    = d_vld;
    res.status = d_status;
    res.value  = (d_status == ctb_pkg::STAT_OK) ? sat : '0;
  end

endmodule

// ===== sv/coupling_table_bilinear_interp.sv =====
// ----------------------------------------------------------------------------
// coupling_table_bilinear_interp
// Path: a query result passes stages A..D and the output register to reach
//   m_tdata/m_tuser; loads give no result. Throughput: one request per cycle
//   with the skid empty, loads and queries mixed, set by single-port banks.
// Reset (rst, synchronous): pipeline and output emptied, registers to their
//   defaults. Table contents are not cleared; read only what was loaded.
// ----------------------------------------------------------------------------
module coupling_table_bilinear_interp (
  input  logic        clk,
  input  logic        rst,

  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, low bit up: table_row_slot[1:0], table_col_slot[3:2], grid_x[8:4],
  //   grid_y[13:9], sample_value[37:14], row orbital[41:38],
  //   column orbital[45:42], disp_x[69:46], disp_y[93:70], disp_z_negative[94]
  input  logic [95:0] s_tdata,
  // tuser: mode[0] (0 load, 1 query)
  input  logic [0:0]  s_tuser,

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: hopping_value[23:0]
  output logic [23:0] m_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_tuser,

  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctb_pkg::cfg_t     cfg;
  ctb_pkg::in_item_t item;
  ctb_pkg::front_t   front;
  ctb_pkg::result_t  res;
  logic              adv;
  logic              accept;
  logic              wr;

  // output register plus one skid entry
  logic                      out_valid;
  logic [ctb_pkg::VAL_W-1:0] out_value;
  ctb_pkg::status_t          out_status;
  logic                      skid_valid;
  logic [ctb_pkg::VAL_W-1:0] skid_value;
  ctb_pkg::status_t          skid_status;

  // ---------------------------------------------------------------------------
  // Register port. Always ready; write lands on the access cycle.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff   <= 22'd196608;
      cfg.inv_x    <= 24'd65536;
      cfg.inv_y    <= 24'd65536;
      cfg.points_x <= 6'd32;
      cfg.points_y <= 6'd32;
      cfg.row_list <= '0;
      cfg.col_list <= '0;
      cfg.counts   <= '0;
    end else if (wr) begin
      case (ctb_pkg::reg_index_t'(paddr[4:2]))
        ctb_pkg::REG_CUTOFF:   cfg.cutoff   <= pwdata[21:0];
        ctb_pkg::REG_INV_X:    cfg.inv_x    <= pwdata[23:0];
        ctb_pkg::REG_INV_Y:    cfg.inv_y    <= pwdata[23:0];
        ctb_pkg::REG_POINTS_X: cfg.points_x <= pwdata[5:0];
        ctb_pkg::REG_POINTS_Y: cfg.points_y <= pwdata[5:0];
        ctb_pkg::REG_ROW_LIST: cfg.row_list <= pwdata[15:0];
        ctb_pkg::REG_COL_LIST: cfg.col_list <= pwdata[15:0];
        ctb_pkg::REG_COUNTS:   cfg.counts   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctb_pkg::reg_index_t'(paddr[4:2]))
      ctb_pkg::REG_CUTOFF:   prdata = 32'(cfg.cutoff);
      ctb_pkg::REG_INV_X:    prdata = 32'(cfg.inv_x);
      ctb_pkg::REG_INV_Y:    prdata = 32'(cfg.inv_y);
      ctb_pkg::REG_POINTS_X: prdata = 32'(cfg.points_x);
      ctb_pkg::REG_POINTS_Y: prdata = 32'(cfg.points_y);
      ctb_pkg::REG_ROW_LIST: prdata = 32'(cfg.row_list);
      ctb_pkg::REG_COL_LIST: prdata = 32'(cfg.col_list);
      ctb_pkg::REG_COUNTS:   prdata = 32'(cfg.counts);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request unpack. The whole pipe moves together; it halts only while the
  // skid entry is occupied, so a waiting result does not block the next
  // request by itself.
  // ---------------------------------------------------------------------------
  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    item.mode            = s_tuser[0];
    item.table_row_slot  = s_tdata[1:0];
    item.table_col_slot  = s_tdata[3:2];
    item.grid_x          = s_tdata[8:4];
    item.grid_y          = s_tdata[13:9];
    item.sample_value    = s_tdata[37:14];
    item.row_orb         = s_tdata[41:38];
    item.col_orb         = s_tdata[45:42];
    item.disp_x          = s_tdata[69:46];
    item.disp_y          = s_tdata[93:70];
    item.disp_z_negative = s_tdata[94];
  end

  // stage A: swap, cutoff square, first matching slot pair
  ctb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .accept (accept),
    .cfg    (cfg),
    .item   (item),
    .stage  (front)
  );

  // stages B..D: position multiply, four-bank table read, blend
  ctb_interp u_interp (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cfg (cfg),
    .a   (front),
    .res (res)
  );

  // ---------------------------------------------------------------------------
  // Output register and skid. A result arrives only while adv is high, i.e.
  // with the skid empty; it goes to the output register if that is free or
  // draining this cycle, else it parks in the skid. A full skid means no new
  // result, so refilling from the skid and taking a new result never meet.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready && skid_valid) begin
      out_value  <= skid_value;
      out_status <= skid_status;
      skid_valid <= 1'b0;
    end else if (adv && res.vld) begin
      if (!out_valid || m_tready) begin
        out_valid  <= 1'b1;
        out_value  <= res.value;
        out_status <= res.status;
      end else begin
        skid_valid  <= 1'b1;
        skid_value  <= res.value;
        skid_status <= res.status;
      end
    end else if (out_valid && m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

endmodule
